// ----- hw/rtl/drr_pkg.sv -----
// Shared types and constants for the deficit round robin scheduler.
// No dependencies; every other file of the block but drr_ram imports this package.
package drr_pkg;

    localparam int FLOWS   = 16;
    localparam int FLOW_W  = 4;
    localparam int ACT_W   = 5;
    localparam int SIZE_W  = 11;
    localparam int TAG_W   = 16;
    localparam int BYTE_W  = 17;
    localparam int STORE_W = TAG_W + SIZE_W;
    localparam int ADDR_W  = 31;
    localparam int DROP_W  = 6;

    localparam logic [SIZE_W-1:0] SIZE_MIN    = 11'd40;
    localparam logic [SIZE_W-1:0] SIZE_MAX    = 11'd1500;
    localparam logic [23:0]       HASH_MOD    = 24'hFFFFFF;
    localparam logic [ADDR_W-1:0] ADDR_MASK   = 31'h0000FFF0;
    localparam logic [DROP_W-1:0] MAX_DROPS   = 6'd38;
    localparam logic [BYTE_W-1:0] DEFICIT_MAX = 17'h1FFFF;
    localparam logic [15:0]       QUANTUM_RST = 16'd250;
    localparam logic [15:0]       LIMIT_RST   = 16'd65535;

    typedef enum logic [1:0] {
        CFG_QUANTUM = 2'd0,
        CFG_LIMIT   = 2'd1,
        CFG_MASK    = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        EV_SERVED  = 2'd0,
        EV_DROPPED = 2'd1,
        EV_EMPTY   = 2'd2,
        EV_REJECT  = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_BAD = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ENQ,
        B_ENQ_SLOT,
        B_TRIM,
        B_SEARCH,
        B_POP_RD,
        B_POP,
        B_DEQ,
        B_DRR,
        B_DRR_CMP
    } back_state_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [FLOW_W-1:0] flow;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

    typedef struct packed {
        logic [15:0] quantum;
        logic [15:0] limit;
        logic        mask;
    } cfg_t;

endpackage

// ----- hw/rtl/drr_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module drr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/drr_front.sv -----
// Front end: takes commands, checks packet sizes and hashes the source address
// into a flow, then pushes the classified command into the queue. Uses drr_pkg.
module drr_front
    import drr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic [ADDR_W-1:0] source_address,
    input  logic [SIZE_W-1:0] packet_size,
    input  logic [TAG_W-1:0]  packet_tag,
    input  logic              mask_mode,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    front_state_t      state_reg, state_next;
    logic              op_reg, op_next;
    logic [ADDR_W-1:0] x_reg, x_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [31:0]       s_reg, s_next;
    logic              zero_reg, zero_next;
    logic [24:0]       fold;
    logic [24:0]       resid;
    logic [24:0]       hval;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        size_reg <= size_next;
        tag_reg  <= tag_next;
        s_reg    <= s_next;
        zero_reg <= zero_next;
    end

    // 2^24 is one modulo 2^24-1, so the high byte folds onto the low bits.
    assign fold  = 25'(s_reg[31:24]) + 25'(s_reg[23:0]);
    assign resid = (fold >= 25'(HASH_MOD)) ? fold - 25'(HASH_MOD) : fold;
    assign hval  = resid + 25'd1;
    assign busy  = (state_reg != F_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        size_next  = size_reg;
        tag_next   = tag_reg;
        s_next     = s_reg;
        zero_next  = zero_reg;
        q_push     = 1'b0;
        q_cmd.flow = zero_reg ? '0 : hval[FLOW_W-1:0];
        q_cmd.size = size_reg;
        q_cmd.tag  = tag_reg;
        if (op_reg)
        begin
            q_cmd.kind = CMD_DEQ;
        end
        else if (size_reg < SIZE_MIN || size_reg > SIZE_MAX)
        begin
            q_cmd.kind = CMD_BAD;
        end
        else
        begin
            q_cmd.kind = CMD_ENQ;
        end
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    x_next     = mask_mode ? (source_address & ADDR_MASK) : source_address;
                    size_next  = packet_size;
                    tag_next   = packet_tag;
                    state_next = F_HASH;
                end
            end
            F_HASH:
            begin
                s_next     = {1'b0, x_reg} + 32'(x_reg >> 8) - 32'(x_reg >> 4) - 32'd1;
                zero_next  = (x_reg == '0);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/drr_queue.sv -----
// Two-entry command queue between the front end and the scheduler core.
// Uses drr_pkg for the command type.
module drr_queue
    import drr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd = entry_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);

endmodule

// ----- hw/rtl/drr_back.sv -----
// Scheduler core: per-flow packet lists, the service ring, overflow drops and
// deficit round robin service. Uses drr_pkg and drr_ram.
module drr_back
    import drr_pkg::*;
#(
    parameter int PACKET_SLOTS = 2048
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_empty,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              result_valid,
    output logic [1:0]        event_kind,
    output logic [FLOW_W-1:0] flow_index,
    output logic [TAG_W-1:0]  result_tag,
    output logic [SIZE_W-1:0] result_size,
    output logic [BYTE_W-1:0] buffered_bytes,
    output logic [11:0]       buffered_packets,
    output logic              last_result
);

    localparam int AW = $clog2(PACKET_SLOTS);
    localparam int CW = $clog2(PACKET_SLOTS + 1);

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;

    logic [AW-1:0]     head_reg [FLOWS];
    logic [AW-1:0]     head_next [FLOWS];
    logic [AW-1:0]     tail_reg [FLOWS];
    logic [AW-1:0]     tail_next [FLOWS];
    logic [FLOW_W-1:0] rnext_reg [FLOWS];
    logic [FLOW_W-1:0] rnext_next [FLOWS];
    logic [FLOW_W-1:0] rprev_reg [FLOWS];
    logic [FLOW_W-1:0] rprev_next [FLOWS];
    logic [CW-1:0]     fcnt_reg [FLOWS];
    logic [CW-1:0]     fcnt_next [FLOWS];
    logic [BYTE_W-1:0] fbytes_reg [FLOWS];
    logic [BYTE_W-1:0] fbytes_next [FLOWS];
    logic [BYTE_W-1:0] deficit_reg [FLOWS];
    logic [BYTE_W-1:0] deficit_next [FLOWS];
    logic [FLOWS-1:0]  turn_reg, turn_next;

    logic [FLOW_W-1:0] cur_reg, cur_next;
    logic [ACT_W-1:0]  active_reg, active_next;
    logic [BYTE_W-1:0] tbytes_reg, tbytes_next;
    logic [CW-1:0]     tpkts_reg, tpkts_next;
    logic [CW-1:0]     fresh_reg, fresh_next;
    logic [CW-1:0]     stack_reg, stack_next;
    logic              use_stack_reg, use_stack_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [AW-1:0]     pop_slot_reg, pop_slot_next;
    logic [FLOW_W-1:0] pf_reg, pf_next;
    logic              serve_reg, serve_next;
    logic [FLOW_W-1:0] best_reg, best_next;
    logic [BYTE_W-1:0] best_bytes_reg, best_bytes_next;
    logic [FLOW_W-1:0] t_reg, t_next;
    logic [ACT_W-1:0]  i_reg, i_next;
    logic [DROP_W-1:0] drops_reg, drops_next;

    logic              res_valid_reg, res_valid_next;
    logic [1:0]        res_kind_reg, res_kind_next;
    logic [FLOW_W-1:0] res_flow_reg, res_flow_next;
    logic [TAG_W-1:0]  res_tag_reg, res_tag_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;
    logic [BYTE_W-1:0] res_bytes_reg, res_bytes_next;
    logic [CW-1:0]     res_pkts_reg, res_pkts_next;
    logic              res_last_reg, res_last_next;

    logic               store_we;
    logic [AW-1:0]      store_waddr;
    logic [STORE_W-1:0] store_wdata;
    logic [AW-1:0]      store_raddr;
    logic [STORE_W-1:0] store_rdata;
    logic               link_we;
    logic [AW-1:0]      link_waddr;
    logic [AW-1:0]      link_wdata;
    logic [AW-1:0]      link_rdata;
    logic               stack_we;
    logic [AW-1:0]      stack_rdata;
    logic [CW-1:0]      stack_m1;

    logic               free_avail;
    logic [15:0]        q_eff;
    logic [AW-1:0]      new_slot;
    logic [BYTE_W:0]    def_sum;
    logic [SIZE_W-1:0]  pop_size;
    logic [BYTE_W-1:0]  pop_tbytes;
    logic [ACT_W-1:0]   pop_active;
    logic               pop_empty;
    logic [FLOW_W-1:0]  rm_next, rm_prev;
    logic [FLOW_W-1:0]  add_prev;
    logic [31:0]        pkts_wide;

    drr_ram #(.WIDTH(STORE_W), .DEPTH(PACKET_SLOTS)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    drr_ram #(.WIDTH(AW), .DEPTH(PACKET_SLOTS)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (store_raddr),
        .rdata (link_rdata)
    );

    // Recycled slots; slots never used yet come from fresh_reg instead.
    drr_ram #(.WIDTH(AW), .DEPTH(PACKET_SLOTS)) u_free (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_reg[AW-1:0]),
        .wdata (pop_slot_reg),
        .raddr (stack_m1[AW-1:0]),
        .rdata (stack_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fcnt_reg      <= '{default: '0};
            fbytes_reg    <= '{default: '0};
            deficit_reg   <= '{default: '0};
            turn_reg      <= '0;
            cur_reg       <= '0;
            active_reg    <= '0;
            tbytes_reg    <= '0;
            tpkts_reg     <= '0;
            fresh_reg     <= '0;
            stack_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcnt_reg      <= fcnt_next;
            fbytes_reg    <= fbytes_next;
            deficit_reg   <= deficit_next;
            turn_reg      <= turn_next;
            cur_reg       <= cur_next;
            active_reg    <= active_next;
            tbytes_reg    <= tbytes_next;
            tpkts_reg     <= tpkts_next;
            fresh_reg     <= fresh_next;
            stack_reg     <= stack_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        rnext_reg      <= rnext_next;
        rprev_reg      <= rprev_next;
        use_stack_reg  <= use_stack_next;
        slot_reg       <= slot_next;
        pop_slot_reg   <= pop_slot_next;
        pf_reg         <= pf_next;
        serve_reg      <= serve_next;
        best_reg       <= best_next;
        best_bytes_reg <= best_bytes_next;
        t_reg          <= t_next;
        i_reg          <= i_next;
        drops_reg      <= drops_next;
        res_kind_reg   <= res_kind_next;
        res_flow_reg   <= res_flow_next;
        res_tag_reg    <= res_tag_next;
        res_size_reg   <= res_size_next;
        res_bytes_reg  <= res_bytes_next;
        res_pkts_reg   <= res_pkts_next;
        res_last_reg   <= res_last_next;
    end

    assign stack_m1   = stack_reg - CW'(1);
    assign free_avail = (fresh_reg != CW'(PACKET_SLOTS)) || (stack_reg != '0);
    assign q_eff      = (cfg.quantum == '0) ? 16'd1 : cfg.quantum;
    assign new_slot   = use_stack_reg ? stack_rdata : slot_reg;
    assign def_sum    = {1'b0, deficit_reg[cur_reg]} + (BYTE_W + 1)'(q_eff);
    assign pop_size   = store_rdata[SIZE_W-1:0];
    assign pop_tbytes = tbytes_reg - BYTE_W'(pop_size);
    assign pop_empty  = (fcnt_reg[pf_reg] == CW'(1));
    assign pop_active = pop_empty ? active_reg - ACT_W'(1) : active_reg;
    assign rm_next    = rnext_reg[pf_reg];
    assign rm_prev    = rprev_reg[pf_reg];
    assign add_prev   = rprev_reg[cur_reg];

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        rnext_next      = rnext_reg;
        rprev_next      = rprev_reg;
        fcnt_next       = fcnt_reg;
        fbytes_next     = fbytes_reg;
        deficit_next    = deficit_reg;
        turn_next       = turn_reg;
        cur_next        = cur_reg;
        active_next     = active_reg;
        tbytes_next     = tbytes_reg;
        tpkts_next      = tpkts_reg;
        fresh_next      = fresh_reg;
        stack_next      = stack_reg;
        use_stack_next  = use_stack_reg;
        slot_next       = slot_reg;
        pop_slot_next   = pop_slot_reg;
        pf_next         = pf_reg;
        serve_next      = serve_reg;
        best_next       = best_reg;
        best_bytes_next = best_bytes_reg;
        t_next          = t_reg;
        i_next          = i_reg;
        drops_next      = drops_reg;
        q_pop           = 1'b0;
        store_we        = 1'b0;
        store_waddr     = new_slot;
        store_wdata     = {cmd_reg.tag, cmd_reg.size};
        store_raddr     = pop_slot_reg;
        link_we         = 1'b0;
        link_waddr      = tail_reg[cmd_reg.flow];
        link_wdata      = new_slot;
        stack_we        = 1'b0;
        res_valid_next  = 1'b0;
        res_kind_next   = res_kind_reg;
        res_flow_next   = res_flow_reg;
        res_tag_next    = res_tag_reg;
        res_size_next   = res_size_reg;
        res_bytes_next  = res_bytes_reg;
        res_pkts_next   = res_pkts_reg;
        res_last_next   = res_last_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    drops_next = '0;
                    state_next = (q_cmd.kind == CMD_DEQ) ? B_DEQ : B_ENQ;
                end
            end
            B_ENQ:
            begin
                if (cmd_reg.kind == CMD_BAD || !free_avail)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = EV_REJECT;
                    res_flow_next  = '0;
                    res_tag_next   = cmd_reg.tag;
                    res_size_next  = cmd_reg.size;
                    res_bytes_next = tbytes_reg;
                    res_pkts_next  = tpkts_reg;
                    res_last_next  = 1'b1;
                    state_next     = B_IDLE;
                end
                else
                begin
                    if (stack_reg != '0)
                    begin
                        use_stack_next = 1'b1;
                        stack_next     = stack_m1;
                    end
                    else
                    begin
                        use_stack_next = 1'b0;
                        slot_next      = fresh_reg[AW-1:0];
                        fresh_next     = fresh_reg + CW'(1);
                    end
                    state_next = B_ENQ_SLOT;
                end
            end
            B_ENQ_SLOT:
            begin
                store_we = 1'b1;
                if (fcnt_reg[cmd_reg.flow] == '0)
                begin
                    head_next[cmd_reg.flow]    = new_slot;
                    deficit_next[cmd_reg.flow] = '0;
                    // A newly active flow joins the ring just before the current one.
                    if (active_reg == '0)
                    begin
                        rnext_next[cmd_reg.flow] = cmd_reg.flow;
                        rprev_next[cmd_reg.flow] = cmd_reg.flow;
                        cur_next                 = cmd_reg.flow;
                    end
                    else
                    begin
                        rprev_next[cmd_reg.flow] = add_prev;
                        rnext_next[cmd_reg.flow] = cur_reg;
                        rnext_next[add_prev]     = cmd_reg.flow;
                        rprev_next[cur_reg]      = cmd_reg.flow;
                    end
                    active_next = active_reg + ACT_W'(1);
                end
                else
                begin
                    link_we = 1'b1;
                end
                tail_next[cmd_reg.flow]   = new_slot;
                fcnt_next[cmd_reg.flow]   = fcnt_reg[cmd_reg.flow] + CW'(1);
                fbytes_next[cmd_reg.flow] = fbytes_reg[cmd_reg.flow] + BYTE_W'(cmd_reg.size);
                tpkts_next                = tpkts_reg + CW'(1);
                tbytes_next               = tbytes_reg + BYTE_W'(cmd_reg.size);
                state_next                = B_TRIM;
            end
            B_TRIM:
            begin
                if (tbytes_reg > BYTE_W'(cfg.limit) && drops_reg < MAX_DROPS
                    && active_reg != '0)
                begin
                    best_next       = cur_reg;
                    best_bytes_next = fbytes_reg[cur_reg];
                    t_next          = rnext_reg[cur_reg];
                    i_next          = ACT_W'(1);
                    state_next      = (active_reg == ACT_W'(1)) ? B_POP_RD : B_SEARCH;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_SEARCH:
            begin
                // Strict compare keeps the first flow in ring order on a tie.
                if (best_bytes_reg < fbytes_reg[t_reg])
                begin
                    best_next       = t_reg;
                    best_bytes_next = fbytes_reg[t_reg];
                end
                t_next = rnext_reg[t_reg];
                i_next = i_reg + ACT_W'(1);
                if (i_reg + ACT_W'(1) == active_reg)
                begin
                    state_next = B_POP_RD;
                end
            end
            B_POP_RD:
            begin
                pf_next       = best_reg;
                serve_next    = 1'b0;
                store_raddr   = head_reg[best_reg];
                pop_slot_next = head_reg[best_reg];
                state_next    = B_POP;
            end
            B_POP:
            begin
                head_next[pf_reg] = link_rdata;
                if (stack_reg != CW'(PACKET_SLOTS))
                begin
                    stack_we   = 1'b1;
                    stack_next = stack_reg + CW'(1);
                end
                fcnt_next[pf_reg]   = fcnt_reg[pf_reg] - CW'(1);
                fbytes_next[pf_reg] = fbytes_reg[pf_reg] - BYTE_W'(pop_size);
                tpkts_next          = tpkts_reg - CW'(1);
                tbytes_next         = pop_tbytes;
                if (serve_reg)
                begin
                    deficit_next[pf_reg] = deficit_reg[pf_reg] - BYTE_W'(pop_size);
                end
                if (pop_empty)
                begin
                    turn_next[pf_reg] = 1'b0;
                    if (serve_reg)
                    begin
                        deficit_next[pf_reg] = '0;
                    end
                    if (active_reg > ACT_W'(1))
                    begin
                        rprev_next[rm_next] = rm_prev;
                        rnext_next[rm_prev] = rm_next;
                        if (cur_reg == pf_reg)
                        begin
                            cur_next = rm_next;
                        end
                    end
                    active_next = pop_active;
                end
                res_valid_next = 1'b1;
                res_kind_next  = serve_reg ? EV_SERVED : EV_DROPPED;
                res_flow_next  = pf_reg;
                res_tag_next   = store_rdata[STORE_W-1:SIZE_W];
                res_size_next  = pop_size;
                res_bytes_next = pop_tbytes;
                res_pkts_next  = tpkts_reg - CW'(1);
                if (serve_reg)
                begin
                    res_last_next = 1'b1;
                    state_next    = B_IDLE;
                end
                else
                begin
                    // Last drop when the next trim check is bound to fail.
                    res_last_next = !(pop_tbytes > BYTE_W'(cfg.limit)
                                      && drops_reg + DROP_W'(1) < MAX_DROPS
                                      && pop_active != '0);
                    drops_next    = drops_reg + DROP_W'(1);
                    state_next    = B_TRIM;
                end
            end
            B_DEQ:
            begin
                if (tpkts_reg == '0 || active_reg == '0)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = EV_EMPTY;
                    res_flow_next  = '0;
                    res_tag_next   = '0;
                    res_size_next  = '0;
                    res_bytes_next = tbytes_reg;
                    res_pkts_next  = tpkts_reg;
                    res_last_next  = 1'b1;
                    state_next     = B_IDLE;
                end
                else
                begin
                    state_next = B_DRR;
                end
            end
            B_DRR:
            begin
                if (!turn_reg[cur_reg])
                begin
                    deficit_next[cur_reg] = (def_sum > {1'b0, DEFICIT_MAX}) ?
                                            DEFICIT_MAX : def_sum[BYTE_W-1:0];
                    turn_next[cur_reg]    = 1'b1;
                end
                store_raddr   = head_reg[cur_reg];
                pop_slot_next = head_reg[cur_reg];
                state_next    = B_DRR_CMP;
            end
            B_DRR_CMP:
            begin
                if (deficit_reg[cur_reg] >= BYTE_W'(pop_size))
                begin
                    pf_next    = cur_reg;
                    serve_next = 1'b1;
                    state_next = B_POP;
                end
                else
                begin
                    turn_next[cur_reg] = 1'b0;
                    cur_next           = rnext_reg[cur_reg];
                    state_next         = B_DRR;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign pkts_wide        = 32'(res_pkts_reg);
    assign result_valid     = res_valid_reg;
    assign event_kind       = res_kind_reg;
    assign flow_index       = res_flow_reg;
    assign result_tag       = res_tag_reg;
    assign result_size      = res_size_reg;
    assign buffered_bytes   = res_bytes_reg;
    assign buffered_packets = pkts_wide[11:0];
    assign last_result      = res_last_reg;

endmodule

// ----- hw/rtl/deficit_round_robin_scheduler.sv -----
// Top level of the deficit round robin packet scheduler: configuration
// registers, front end, command queue and scheduler core. Uses drr_pkg.

// A command is taken when start is high and busy is low. Busy stays high while
// the front end hashes the address and pushes the command, and longer while
// the two-entry command queue is full. The core then works through commands
// in order. A rejected or empty command gets its result from the first check.
// An enqueue stores the packet and checks the byte limit; each drop walks the
// ring for the fullest flow and pops its head packet. A dequeue visits flows
// in round robin order until one can serve its head packet. Results appear for
// one cycle on result_valid and cannot be held off, so they must be captured
// on that cycle. last_result marks the final result of a command. There is no
// reset sweep: the block takes commands from the first cycle after reset.
module deficit_round_robin_scheduler
    import drr_pkg::*;
#(
    parameter int PACKET_SLOTS = 2048
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic [ADDR_W-1:0] source_address,
    input  logic [SIZE_W-1:0] packet_size,
    input  logic [TAG_W-1:0]  packet_tag,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output logic              result_valid,
    output logic [1:0]        event_kind,
    output logic [FLOW_W-1:0] flow_index,
    output logic [TAG_W-1:0]  result_tag,
    output logic [SIZE_W-1:0] result_size,
    output logic [BYTE_W-1:0] buffered_bytes,
    output logic [11:0]       buffered_packets,
    output logic              last_result
);

    cfg_t cfg_reg;
    cmd_t push_cmd, head_cmd;
    logic q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quantum <= QUANTUM_RST;
            cfg_reg.limit   <= LIMIT_RST;
            cfg_reg.mask    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_QUANTUM: cfg_reg.quantum <= cfg_data;
                CFG_LIMIT:   cfg_reg.limit   <= cfg_data;
                CFG_MASK:    cfg_reg.mask    <= cfg_data[0];
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    drr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .source_address (source_address),
        .packet_size    (packet_size),
        .packet_tag     (packet_tag),
        .mask_mode      (cfg_reg.mask),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (push_cmd)
    );

    drr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    drr_back #(.PACKET_SLOTS(PACKET_SLOTS)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_empty          (q_empty),
        .q_cmd            (head_cmd),
        .q_pop            (q_pop),
        .result_valid     (result_valid),
        .event_kind       (event_kind),
        .flow_index       (flow_index),
        .result_tag       (result_tag),
        .result_size      (result_size),
        .buffered_bytes   (buffered_bytes),
        .buffered_packets (buffered_packets),
        .last_result      (last_result)
    );

endmodule

// ----- hw/rtl/drr_checker.sv -----
// Port-level checks for the deficit round robin scheduler, bound to its top
// level. Uses drr_pkg.
module drr_checker
    import drr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input logic [1:0]        event_kind,
    input logic [FLOW_W-1:0] flow_index,
    input logic [TAG_W-1:0]  result_tag,
    input logic [SIZE_W-1:0] result_size,
    input logic              last_result
);

    // An accepted transaction always occupies the hash stage for a while.
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted transaction");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_kind == EV_EMPTY |->
        flow_index == '0 && result_tag == '0 && result_size == '0 && last_result)
        else $error("empty result carries packet data");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (event_kind == EV_SERVED || event_kind == EV_REJECT) |->
        last_result)
        else $error("served or rejected result not marked last");

    a_served_size: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_kind == EV_SERVED |->
        result_size >= SIZE_MIN && result_size <= SIZE_MAX)
        else $error("served packet has a size that is never stored");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results on consecutive cycles");

endmodule

bind deficit_round_robin_scheduler drr_checker u_drr_checker (.*);

// ----- tb/sv/tb_deficit_round_robin_scheduler.sv -----
// Self-checking testbench for the deficit round robin packet scheduler.
// Predicts every result from its own model of flows and ring; needs drr_pkg and the top.
module tb_deficit_round_robin_scheduler;
    import drr_pkg::*;

    localparam int SLOTS      = 2048;
    localparam int IDLE_WAIT  = 400;
    localparam int STALL_MAX  = 60000;

    typedef struct {
        event_kind_t       kind;
        logic [3:0]        flow;
        logic [15:0]       tag;
        logic [10:0]       size;
        logic [16:0]       bytes;
        logic [11:0]       packets;
        logic              last;
    } sched_event_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              operation = 1'b0;
    logic [30:0]       source_address = '0;
    logic [10:0]       packet_size = '0;
    logic [15:0]       packet_tag = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [15:0]       cfg_data = '0;
    logic              result_valid;
    logic [1:0]        event_kind;
    logic [3:0]        flow_index;
    logic [15:0]       result_tag;
    logic [10:0]       result_size;
    logic [16:0]       buffered_bytes;
    logic [11:0]       buffered_packets;
    logic              last_result;

    deficit_round_robin_scheduler i_dut (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    // Scheduler model state.
    logic [26:0] slot_word [SLOTS];
    logic [10:0] slot_next [SLOTS];
    int unsigned free_stack [SLOTS];
    int unsigned free_depth;
    int unsigned q_head [16], q_tail [16], q_pkts [16], q_bytes [16];
    int unsigned q_deficit [16], q_turn [16], ring_fwd [16], ring_back [16];
    int unsigned serve_flow, ring_size, sum_bytes, sum_pkts;
    int unsigned quantum_reg, limit_reg, mask_reg;

    sched_event_t pending_events [$];
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    int           burst_left = 0;

    function automatic int unsigned hash_flow(input logic [30:0] addr);
        int unsigned x, s;
        x = addr;
        if (mask_reg != 0) x = x & 32'h0000fff0;
        if (x == 0) return 0;
        s = x + (x >> 8) - (x >> 4) - 1;
        return ((s % 32'hffffff) + 1) % 16;
    endfunction

    function automatic void push_event(input event_kind_t k, input int unsigned f,
                                       input int unsigned t, input int unsigned sz);
        sched_event_t e;
        e.kind = k;
        e.flow = f[3:0];
        e.tag = t[15:0];
        e.size = sz[10:0];
        e.bytes = sum_bytes[16:0];
        e.packets = sum_pkts[11:0];
        e.last = 1'b0;
        pending_events.push_back(e);
    endfunction

    function automatic void ring_unlink(input int unsigned f);
        if (ring_size > 1) begin
            ring_back[ring_fwd[f]] = ring_back[f];
            ring_fwd[ring_back[f]] = ring_fwd[f];
            if (serve_flow == f) serve_flow = ring_fwd[f];
        end
        if (ring_size > 0) ring_size--;
    endfunction

    function automatic logic [26:0] pop_packet(input int unsigned f);
        int unsigned slot;
        logic [26:0] w;
        slot = q_head[f];
        w = slot_word[slot];
        q_head[f] = slot_next[slot];
        if (free_depth < SLOTS) begin
            free_stack[free_depth] = slot;
            free_depth++;
        end
        q_pkts[f]--;
        q_bytes[f] -= w[10:0];
        sum_pkts--;
        sum_bytes -= w[10:0];
        return w;
    endfunction

    function automatic void sched_reset();
        quantum_reg = 250;
        limit_reg = 65535;
        mask_reg = 0;
        for (int i = 0; i < SLOTS; i++) free_stack[i] = i;
        free_depth = SLOTS;
        for (int i = 0; i < 16; i++) begin
            q_head[i] = 0; q_tail[i] = 0; q_pkts[i] = 0; q_bytes[i] = 0;
            q_deficit[i] = 0; q_turn[i] = 0; ring_fwd[i] = 0; ring_back[i] = 0;
        end
        serve_flow = 0; ring_size = 0; sum_bytes = 0; sum_pkts = 0;
    endfunction

    // Appends the expected results of one transaction to pending_events.
    function automatic void predict_events(input logic op, input logic [30:0] addr,
                                           input logic [10:0] sz, input logic [15:0] tg);
        int unsigned f, slot, best, walk, q, nres, c, d;
        logic [26:0] w;
        bit done;
        nres = 0;
        if (op == 1'b0) begin
            if (sz < 40 || sz > 1500 || free_depth == 0) begin
                push_event(EV_REJECT, 0, tg, sz);
                nres = 1;
            end else begin
                f = hash_flow(addr);
                free_depth--;
                slot = free_stack[free_depth];
                slot_word[slot] = {tg, sz};
                slot_next[slot] = 0;
                if (q_pkts[f] == 0) q_head[f] = slot;
                else slot_next[q_tail[f]] = slot;
                q_tail[f] = slot;
                q_pkts[f]++;
                q_bytes[f] += sz;
                sum_pkts++;
                sum_bytes += sz;
                if (q_pkts[f] == 1) begin
                    if (ring_size == 0) begin
                        ring_fwd[f] = f; ring_back[f] = f; serve_flow = f;
                    end else begin
                        ring_back[f] = ring_back[serve_flow];
                        ring_fwd[f] = serve_flow;
                        ring_fwd[ring_back[serve_flow]] = f;
                        ring_back[serve_flow] = f;
                    end
                    ring_size++;
                    q_deficit[f] = 0;
                end
                while (sum_bytes > limit_reg && nres < 38 && ring_size > 0) begin
                    best = serve_flow;
                    walk = serve_flow;
                    for (int i = 0; i < ring_size; i++) begin
                        if (q_bytes[best] < q_bytes[walk]) best = walk;
                        walk = ring_fwd[walk];
                    end
                    w = pop_packet(best);
                    if (q_pkts[best] == 0) begin
                        q_turn[best] = 0;
                        ring_unlink(best);
                    end
                    push_event(EV_DROPPED, best, w[26:11], w[10:0]);
                    nres++;
                end
            end
        end else begin
            q = (quantum_reg != 0) ? quantum_reg : 1;
            if (sum_pkts == 0 || ring_size == 0) begin
                push_event(EV_EMPTY, 0, 0, 0);
                nres = 1;
            end else begin
                done = 1'b0;
                while (!done) begin
                    c = serve_flow;
                    if (q_turn[c] == 0) begin
                        d = q_deficit[c] + q;
                        q_deficit[c] = (d > 32'h1ffff) ? 32'h1ffff : d;
                        q_turn[c] = 1;
                    end
                    if (q_deficit[c] >= slot_word[q_head[c]][10:0]) begin
                        q_deficit[c] -= slot_word[q_head[c]][10:0];
                        w = pop_packet(c);
                        if (q_pkts[c] == 0) begin
                            q_turn[c] = 0;
                            q_deficit[c] = 0;
                            ring_unlink(c);
                        end
                        push_event(EV_SERVED, c, w[26:11], w[10:0]);
                        nres = 1;
                        done = 1'b1;
                    end else begin
                        q_turn[c] = 0;
                        serve_flow = ring_fwd[c];
                    end
                end
            end
        end
        if (nres > 0) pending_events[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Sends one transaction; called at a rising edge, returns at the edge that took it.
    task automatic send_item(input logic op, input logic [30:0] addr,
                             input logic [10:0] sz, input logic [15:0] tg);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        start <= 1'b1;
        operation <= op;
        source_address <= addr;
        packet_size <= sz;
        packet_tag <= tg;
        forever begin
            @(negedge clk);
            if (!busy) break;
            @(posedge clk);
        end
        @(posedge clk);
        predict_events(op, addr, sz, tg);
    endtask

    task automatic enqueue(input logic [30:0] addr, input logic [10:0] sz,
                           input logic [15:0] tg);
        send_item(1'b0, addr, sz, tg);
    endtask

    task automatic dequeue();
        send_item(1'b1, 31'($urandom), 11'($urandom), 16'($urandom));
    endtask

    // Waits for every result plus time for a silent enqueue to finish.
    task automatic wait_idle();
        start <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        forever begin
            @(negedge clk);
            if (cfg_ready) break;
            @(posedge clk);
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_QUANTUM: quantum_reg = value;
            CFG_LIMIT:   limit_reg = value;
            CFG_MASK:    mask_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic drain_all();
        while (sum_pkts != 0) dequeue();
    endtask

    task automatic test_edges();
        dequeue();
        enqueue(31'd0, 11'd0, 16'h0000);
        enqueue(31'd1, 11'd39, 16'hffff);
        enqueue(31'd2, 11'd1501, 16'h5a5a);
        enqueue(31'd3, 11'd2047, 16'ha5a5);
        enqueue(31'd0, 11'd40, 16'h0000);
        enqueue(31'h7fffffff, 11'd1500, 16'hffff);
        enqueue(31'h55555555, 11'd700, 16'h1234);
        enqueue(31'h2aaaaaaa, 11'd41, 16'h4321);
        enqueue(31'h7fffffff, 11'd1499, 16'h0f0f);
        repeat (6) dequeue();
    endtask

    task automatic test_mask_and_quantum();
        write_reg(CFG_MASK, 16'd1);
        for (int i = 0; i < 6; i++)
            enqueue(31'($urandom), 11'($urandom_range(40, 1500)), 16'($urandom));
        repeat (3) dequeue();
        write_reg(CFG_QUANTUM, 16'd65535);
        drain_all();
        write_reg(CFG_MASK, 16'd0);
        // Tiny quantum: many empty turns before a small packet goes out.
        write_reg(CFG_QUANTUM, 16'd0);
        enqueue(31'h00001234, 11'd40, 16'hbeef);
        dequeue();
        write_reg(CFG_QUANTUM, 16'd1);
        enqueue(31'h00000077, 11'd45, 16'hcafe);
        enqueue(31'h00000078, 11'd40, 16'hf00d);
        drain_all();
        write_reg(CFG_QUANTUM, 16'd250);
    endtask

    task automatic test_drop_burst();
        for (int i = 0; i < 45; i++)
            enqueue(31'($urandom), 11'($urandom_range(40, 120)), 16'($urandom));
        write_reg(CFG_LIMIT, 16'd0);
        enqueue(31'd5, 11'd60, 16'h7777);
        enqueue(31'd6, 11'd60, 16'h8888);
        enqueue(31'd7, 11'd60, 16'h9999);
        dequeue();
        write_reg(CFG_LIMIT, 16'd3000);
        for (int i = 0; i < 12; i++)
            enqueue(31'($urandom_range(0, 40)), 11'($urandom_range(40, 1500)), 16'($urandom));
        drain_all();
        write_reg(CFG_LIMIT, 16'd65535);
    endtask

    task automatic test_random(input int count);
        logic [30:0] addr_pool [8];
        logic [10:0] sz;
        logic [30:0] addr;
        for (int i = 0; i < 8; i++) addr_pool[i] = 31'($urandom);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) write_reg(CFG_LIMIT, 16'($urandom_range(4000, 20000)));
            if (i == 3 * count / 4) write_reg(CFG_QUANTUM, 16'($urandom_range(40, 1600)));
            if ($urandom_range(0, 9) < 6) begin
                addr = ($urandom_range(0, 2) == 0) ? 31'($urandom)
                                                   : addr_pool[$urandom_range(0, 7)];
                sz = ($urandom_range(0, 9) == 0) ? 11'($urandom)
                                                 : 11'($urandom_range(40, 1500));
                enqueue(addr, sz, 16'($urandom));
            end else begin
                dequeue();
            end
        end
    endtask

    // Results cannot be held off, so each one is taken on its only cycle.
    always @(negedge clk) begin
        sched_event_t e;
        if (rst_n && result_valid) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected result, kind", event_kind, -1);
            end else begin
                e = pending_events.pop_front();
                if (event_kind != e.kind) report_mismatch("event_kind", event_kind, e.kind);
                if (flow_index != e.flow) report_mismatch("flow_index", flow_index, e.flow);
                if (result_tag != e.tag) report_mismatch("result_tag", result_tag, e.tag);
                if (result_size != e.size) report_mismatch("result_size", result_size, e.size);
                if (buffered_bytes != e.bytes)
                    report_mismatch("buffered_bytes", buffered_bytes, e.bytes);
                if (buffered_packets != e.packets)
                    report_mismatch("buffered_packets", buffered_packets, e.packets);
                if (last_result != e.last) report_mismatch("last_result", last_result, e.last);
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        sched_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edges();
        test_mask_and_quantum();
        test_drop_burst();
        test_random(120);
        write_reg(CFG_LIMIT, 16'd65535);
        drain_all();
        wait_idle();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/drr_pkg.sv
hw/rtl/drr_ram.sv
hw/rtl/drr_front.sv
hw/rtl/drr_queue.sv
hw/rtl/drr_back.sv
hw/rtl/deficit_round_robin_scheduler.sv
hw/rtl/drr_checker.sv
tb/sv/tb_deficit_round_robin_scheduler.sv
